@@ src/ptsd_pkg.sv @@
// Shared types and constants for the point-to-segment distance block.
package ptsd_pkg;

    localparam int UNIT_BITS    = 30;
    localparam int QUEUE_DEPTH  = 8;
    localparam int FRONT_STAGES = 3;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] seg_start_x;
        logic signed [31:0] seg_start_y;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] seg_length;
    } t_query;

    // classified query: prescaled direction magnitudes plus signs
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] seg_start_x;
        logic signed [31:0] seg_start_y;
        logic signed [31:0] seg_length;
        logic               neg_x;
        logic               neg_y;
        logic               zero;
        logic [31:0]        ax;
        logic [31:0]        ay;
    } t_front_word;

    typedef struct packed {
        logic signed [32:0] fx;
        logic signed [32:0] fy;
        logic signed [31:0] len;
        logic               neg_x;
        logic               neg_y;
        logic               zero;
        logic [31:0]        ax;
        logic [31:0]        ay;
    } t_geo;

    typedef struct packed {
        logic signed [32:0] fx;
        logic signed [32:0] fy;
        logic signed [31:0] len;
        logic               neg_x;
        logic               zero;
    } t_proj;

endpackage

@@ src/ptsd_front.sv @@
// Front end: registers queries, takes direction magnitudes and prescales them.
module ptsd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ptsd_pkg::t_query     i_query,
    output logic                 o_valid,
    output ptsd_pkg::t_front_word o_word
);
    logic                  r_v0, r_v1, r_v2;
    ptsd_pkg::t_query      r_q0;
    ptsd_pkg::t_front_word r_s1, r_word;
    ptsd_pkg::t_front_word n_s1, n_word;
    logic [31:0]           r_m1, n_m1;
    logic [31:0]           ax, ay, m;

    always_comb begin
        ax = r_q0.dir_x[31] ? 32'(-r_q0.dir_x) : r_q0.dir_x;
        ay = r_q0.dir_y[31] ? 32'(-r_q0.dir_y) : r_q0.dir_y;
        m  = (ax > ay) ? ax : ay;
        n_s1.point_x     = r_q0.point_x;
        n_s1.point_y     = r_q0.point_y;
        n_s1.seg_start_x = r_q0.seg_start_x;
        n_s1.seg_start_y = r_q0.seg_start_y;
        n_s1.seg_length  = r_q0.seg_length;
        n_s1.neg_x       = r_q0.dir_x[31];
        n_s1.neg_y       = r_q0.dir_y[31];
        n_s1.zero        = (m == 32'd0);
        n_s1.ax          = ax;
        n_s1.ay          = ay;
        n_m1             = m;
        if (n_m1 < 32'h0000_8000) begin
            n_m1 = n_m1 << 16; n_s1.ax = n_s1.ax << 16; n_s1.ay = n_s1.ay << 16;
        end
        if (n_m1 < 32'h0080_0000) begin
            n_m1 = n_m1 << 8; n_s1.ax = n_s1.ax << 8; n_s1.ay = n_s1.ay << 8;
        end
    end

    always_comb begin
        logic [31:0] mm;
        mm     = r_m1;
        n_word = r_s1;
        if (mm < 32'h0800_0000) begin
            mm = mm << 4; n_word.ax = n_word.ax << 4; n_word.ay = n_word.ay << 4;
        end
        if (mm < 32'h2000_0000) begin
            mm = mm << 2; n_word.ax = n_word.ax << 2; n_word.ay = n_word.ay << 2;
        end
        if (mm < 32'h4000_0000) begin
            n_word.ax = n_word.ax << 1; n_word.ay = n_word.ay << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
        if (i_valid) r_q0 <= i_query;
        r_s1   <= n_s1;
        r_m1   <= n_m1;
        r_word <= n_word;
    end

    assign o_valid = r_v2;
    assign o_word  = r_word;
endmodule

@@ src/ptsd_queue.sv @@
// Short word queue between front and back, with an almost-full flag for start gating.
module ptsd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ptsd_pkg::t_front_word i_word,
    output logic                  o_valid,
    output ptsd_pkg::t_front_word o_word,
    output logic                  o_almost_full
);
    localparam int DEPTH = ptsd_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    ptsd_pkg::t_front_word mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_count, n_count;
    logic          pop;
    logic          r_out_valid;
    ptsd_pkg::t_front_word r_out;

    assign pop = (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) n_count = r_count + 1'b1;
        if (!i_push && pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) mem[r_wr] <= i_word;
        if (pop) r_out <= mem[r_rd];
        if (!i_rst_n) begin
            r_wr        <= '0;
            r_rd        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (pop) r_rd <= r_rd + 1'b1;
            r_count     <= n_count;
            r_out_valid <= pop;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_word        = r_out;
    assign o_almost_full = (r_count >= (AW+1)'(DEPTH - ptsd_pkg::FRONT_STAGES));
endmodule

@@ src/ptsd_isqrt.sv @@
// Pipelined integer square root, one result bit per stage, with side data.
module ptsd_isqrt #(
    parameter int W      = 64,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [W-1:0]      i_data,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [W/2-1:0]    o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int STEPS = W / 2;

    logic [W-1:0]      w_rem  [STEPS+1];
    logic [W-1:0]      w_res  [STEPS+1];
    logic              w_vld  [STEPS+1];
    logic [SIDE_W-1:0] w_side [STEPS+1];
    logic [W-1:0]      r_rem  [STEPS];
    logic [W-1:0]      r_res  [STEPS];
    logic              r_vld  [STEPS];
    logic [SIDE_W-1:0] r_side [STEPS];

    assign w_rem[0]  = i_data;
    assign w_res[0]  = '0;
    assign w_vld[0]  = i_valid;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic [W-1:0] BITV = W'(1) << (W - 2 - 2*k);
        logic [W-1:0] trial, n_rem, n_res;
        always_comb begin
            trial = w_res[k] + BITV;
            if (w_rem[k] >= trial) begin
                n_rem = w_rem[k] - trial;
                n_res = (w_res[k] >> 1) + BITV;
            end else begin
                n_rem = w_rem[k];
                n_res = w_res[k] >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld[k] <= 1'b0;
            else          r_vld[k] <= w_vld[k];
            r_rem[k]  <= n_rem;
            r_res[k]  <= n_res;
            r_side[k] <= w_side[k];
        end
        assign w_rem[k+1]  = r_rem[k];
        assign w_res[k+1]  = r_res[k];
        assign w_vld[k+1]  = r_vld[k];
        assign w_side[k+1] = r_side[k];
    end

    assign o_valid = w_vld[STEPS];
    assign o_root  = w_res[STEPS][W/2-1:0];
    assign o_side  = w_side[STEPS];
endmodule

@@ src/ptsd_div.sv @@
// Pipelined restoring divider, one quotient bit per stage; quotient must fit QW bits.
module ptsd_div #(
    parameter int DW     = 32,
    parameter int QW     = 31,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [QW+DW-1:0]  i_num,
    input  logic [DW-1:0]     i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QW-1:0]     o_quot,
    output logic [SIDE_W-1:0] o_side
);
    logic [DW-1:0]     w_rem  [QW+1];
    logic [QW-1:0]     w_low  [QW+1];
    logic [QW-1:0]     w_q    [QW+1];
    logic [DW-1:0]     w_den  [QW+1];
    logic              w_vld  [QW+1];
    logic [SIDE_W-1:0] w_side [QW+1];
    logic [DW-1:0]     r_rem  [QW];
    logic [QW-1:0]     r_low  [QW];
    logic [QW-1:0]     r_q    [QW];
    logic [DW-1:0]     r_den  [QW];
    logic              r_vld  [QW];
    logic [SIDE_W-1:0] r_side [QW];

    assign w_rem[0]  = i_num[QW+DW-1:QW];
    assign w_low[0]  = i_num[QW-1:0];
    assign w_q[0]    = '0;
    assign w_den[0]  = i_den;
    assign w_vld[0]  = i_valid;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0]   trial;
        logic [DW-1:0] n_rem;
        logic          qbit;
        always_comb begin
            trial = {w_rem[k], w_low[k][QW-1]};
            qbit  = (trial >= {1'b0, w_den[k]});
            n_rem = qbit ? DW'(trial - {1'b0, w_den[k]}) : trial[DW-1:0];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld[k] <= 1'b0;
            else          r_vld[k] <= w_vld[k];
            r_rem[k]  <= n_rem;
            r_low[k]  <= w_low[k] << 1;
            r_q[k]    <= {w_q[k][QW-2:0], qbit};
            r_den[k]  <= w_den[k];
            r_side[k] <= w_side[k];
        end
        assign w_rem[k+1]  = r_rem[k];
        assign w_low[k+1]  = r_low[k];
        assign w_q[k+1]    = r_q[k];
        assign w_den[k+1]  = r_den[k];
        assign w_vld[k+1]  = r_vld[k];
        assign w_side[k+1] = r_side[k];
    end

    assign o_valid = w_vld[QW];
    assign o_quot  = w_q[QW];
    assign o_side  = w_side[QW];
endmodule

@@ src/ptsd_back.sv @@
// Back end: unit vector, projection, clamp, residual and final distance root.
module ptsd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  ptsd_pkg::t_front_word i_word,
    output logic                  o_strobe,
    output logic [31:0]           o_distance
);
    localparam int UB = ptsd_pkg::UNIT_BITS;

    // stage 0: offsets and squared magnitudes
    logic            r_v0;
    ptsd_pkg::t_geo  r_geo, n_geo;
    logic [63:0]     r_sqx, r_sqy;

    always_comb begin
        n_geo.fx    = {i_word.point_x[31], i_word.point_x}
                    - {i_word.seg_start_x[31], i_word.seg_start_x};
        n_geo.fy    = {i_word.point_y[31], i_word.point_y}
                    - {i_word.seg_start_y[31], i_word.seg_start_y};
        n_geo.len   = i_word.seg_length;
        n_geo.neg_x = i_word.neg_x;
        n_geo.neg_y = i_word.neg_y;
        n_geo.zero  = i_word.zero;
        n_geo.ax    = i_word.ax;
        n_geo.ay    = i_word.ay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else          r_v0 <= i_valid;
        r_geo <= n_geo;
        r_sqx <= i_word.ax * i_word.ax;
        r_sqy <= i_word.ay * i_word.ay;
    end

    // magnitude
    logic           mag_v;
    logic [31:0]    mag;
    ptsd_pkg::t_geo mag_geo;

    ptsd_isqrt #(.W(64), .SIDE_W($bits(ptsd_pkg::t_geo))) u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_data  (r_sqx + r_sqy),
        .i_side  (r_geo),
        .o_valid (mag_v),
        .o_root  (mag),
        .o_side  (mag_geo)
    );

    // unit vector components
    ptsd_pkg::t_proj div_side, dx_side;
    logic            dx_v, dy_v_unused_side;
    logic [30:0]     qx, qy;
    logic            dy_neg;

    always_comb begin
        div_side.fx    = mag_geo.fx;
        div_side.fy    = mag_geo.fy;
        div_side.len   = mag_geo.len;
        div_side.neg_x = mag_geo.neg_x;
        div_side.zero  = mag_geo.zero;
    end

    ptsd_div #(.DW(32), .QW(31), .SIDE_W($bits(ptsd_pkg::t_proj))) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mag_v),
        .i_num   ({1'b0, mag_geo.ax, UB'(0)}),
        .i_den   (mag),
        .i_side  (div_side),
        .o_valid (dx_v),
        .o_quot  (qx),
        .o_side  (dx_side)
    );

    ptsd_div #(.DW(32), .QW(31), .SIDE_W(1)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mag_v),
        .i_num   ({1'b0, mag_geo.ay, UB'(0)}),
        .i_den   (mag),
        .i_side  (mag_geo.neg_y),
        .o_valid (dy_v_unused_side),
        .o_quot  (qy),
        .o_side  (dy_neg)
    );

    // stage 2: signed unit vector
    logic               r_v2;
    logic signed [31:0] r_ux2, r_uy2, n_ux, n_uy;
    logic signed [32:0] r_fx2, r_fy2;
    logic signed [31:0] r_len2;

    always_comb begin
        n_ux = dx_side.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        n_uy = dy_neg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
        if (dx_side.zero) begin
            n_ux = '0;
            n_uy = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= dx_v & dy_v_unused_side;
        r_ux2  <= n_ux;
        r_uy2  <= n_uy;
        r_fx2  <= dx_side.fx;
        r_fy2  <= dx_side.fy;
        r_len2 <= dx_side.len;
    end

    // stage 3: projection products
    logic               r_v3;
    logic signed [64:0] r_px3, r_py3;
    logic signed [31:0] r_ux3, r_uy3, r_len3;
    logic signed [32:0] r_fx3, r_fy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_v2;
        r_px3  <= r_ux2 * r_fx2;
        r_py3  <= r_uy2 * r_fy2;
        r_ux3  <= r_ux2;
        r_uy3  <= r_uy2;
        r_fx3  <= r_fx2;
        r_fy3  <= r_fy2;
        r_len3 <= r_len2;
    end

    // stage 4: floor to raw units and clamp
    logic               r_v4;
    logic signed [65:0] dot;
    logic signed [35:0] t, len_ext;
    logic signed [31:0] n_tc, r_tc4, r_ux4, r_uy4;
    logic signed [32:0] r_fx4, r_fy4;

    always_comb begin
        dot     = {r_px3[64], r_px3} + {r_py3[64], r_py3};
        t       = dot[65:UB];
        len_ext = {{4{r_len3[31]}}, r_len3};
        priority if (t >= len_ext) n_tc = r_len3;
        else if (t <= 36'sd0)      n_tc = '0;
        else                       n_tc = t[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else          r_v4 <= r_v3;
        r_tc4 <= n_tc;
        r_ux4 <= r_ux3;
        r_uy4 <= r_uy3;
        r_fx4 <= r_fx3;
        r_fy4 <= r_fy3;
    end

    // stage 5: foot offsets
    logic               r_v5;
    logic signed [63:0] r_mx5, r_my5;
    logic signed [32:0] r_fx5, r_fy5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else          r_v5 <= r_v4;
        r_mx5 <= r_ux4 * r_tc4;
        r_my5 <= r_uy4 * r_tc4;
        r_fx5 <= r_fx4;
        r_fy5 <= r_fy4;
    end

    // stage 6: residuals, rounded magnitudes
    logic               r_v6;
    logic signed [64:0] ex, ey;
    logic [64:0]        ax_e, ay_e;
    logic [65:0]        rx, ry;
    logic [34:0]        r_ex6, r_ey6;

    always_comb begin
        ex   = {{2{r_fx5[32]}}, r_fx5, UB'(0)} - {r_mx5[63], r_mx5};
        ey   = {{2{r_fy5[32]}}, r_fy5, UB'(0)} - {r_my5[63], r_my5};
        ax_e = ex[64] ? 65'(-ex) : ex;
        ay_e = ey[64] ? 65'(-ey) : ey;
        rx   = {1'b0, ax_e} + (66'd1 << (UB - 1));
        ry   = {1'b0, ay_e} + (66'd1 << (UB - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v6 <= 1'b0;
        else          r_v6 <= r_v5;
        r_ex6 <= rx[UB+34:UB];
        r_ey6 <= ry[UB+34:UB];
    end

    // stage 7: squares, overflow of a single axis
    logic        r_v7, r_sat7;
    logic [63:0] r_sqx7, r_sqy7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v7 <= 1'b0;
        else          r_v7 <= r_v6;
        r_sat7 <= (|r_ex6[34:32]) | (|r_ey6[34:32]);
        r_sqx7 <= r_ex6[31:0] * r_ex6[31:0];
        r_sqy7 <= r_ey6[31:0] * r_ey6[31:0];
    end

    // final root
    logic [64:0] sum;
    logic        dist_v, dist_sat;
    logic [31:0] root;

    assign sum = {1'b0, r_sqx7} + {1'b0, r_sqy7};

    ptsd_isqrt #(.W(64), .SIDE_W(1)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v7),
        .i_data  (sum[63:0]),
        .i_side  (r_sat7 | sum[64]),
        .o_valid (dist_v),
        .o_root  (root),
        .o_side  (dist_sat)
    );

    assign o_strobe   = dist_v;
    assign o_distance = dist_sat ? 32'hFFFF_FFFF : root;
endmodule

@@ src/point_to_segment_distance.sv @@
// Top level of the point-to-segment distance block.
// A query is taken on every clock edge with start high and busy low, so one query per
// cycle is sustained. Each distance appears on o_distance for a single cycle with
// o_strobe high. Between the edge that accepts its query and that cycle lie the front
// end, the queue, the two 32-stage square-root pipelines and the two 31-stage dividers
// that form the unit vector. Results leave in query order and cannot be held off.
module point_to_segment_distance (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_seg_start_x,
    input  logic [31:0] i_seg_start_y,
    input  logic [31:0] i_dir_x,
    input  logic [31:0] i_dir_y,
    input  logic [31:0] i_seg_length,
    output logic        o_strobe,
    output logic [31:0] o_distance
);
    ptsd_pkg::t_query      query;
    ptsd_pkg::t_front_word f_word, q_word;
    logic                  f_valid, q_valid, almost_full;

    assign query = '{point_x: i_point_x, point_y: i_point_y,
                     seg_start_x: i_seg_start_x, seg_start_y: i_seg_start_y,
                     dir_x: i_dir_x, dir_y: i_dir_y, seg_length: i_seg_length};

    assign busy = almost_full;

    ptsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~almost_full),
        .i_query (query),
        .o_valid (f_valid),
        .o_word  (f_word)
    );

    ptsd_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (f_valid),
        .i_word        (f_word),
        .o_valid       (q_valid),
        .o_word        (q_word),
        .o_almost_full (almost_full)
    );

    ptsd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_word     (q_word),
        .o_strobe   (o_strobe),
        .o_distance (o_distance)
    );
endmodule

@@ tb/sv/point_to_segment_distance_checker.sv @@
// Checker for the point-to-segment distance block: predicts each distance and compares.
module point_to_segment_distance_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_seg_start_x,
    input  logic [31:0] i_seg_start_y,
    input  logic [31:0] i_dir_x,
    input  logic [31:0] i_dir_y,
    input  logic [31:0] i_seg_length,
    input  logic        o_strobe,
    input  logic [31:0] o_distance,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UB = ptsd_pkg::UNIT_BITS;
    localparam longint UNIT_ONE = longint'(1) << UB;

    logic [31:0] distance_q[$];

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned magnitude(longint x);
        return x < 0 ? longint'(0) - x : x;
    endfunction

    function automatic longint floor_div_unit(longint x);
        longint unsigned m;
        if (x >= 0) return x >>> UB;
        m = longint'(0) - x;
        return -longint'((m + longint'(UNIT_ONE - 1)) >> UB);
    endfunction

    function automatic longint unsigned rounded_residual(longint e);
        return (magnitude(e) + (64'd1 << (UB - 1))) >> UB;
    endfunction

    function automatic logic [31:0] seg_distance(logic signed [31:0] px, logic signed [31:0] py,
            logic signed [31:0] sx, logic signed [31:0] sy, logic signed [31:0] dx,
            logic signed [31:0] dy, logic signed [31:0] len);
        longint unsigned ax, ay, m, mag, ex, ey, sqx, sqy, sum;
        longint ux, uy, fx, fy, t, tc;
        ax = magnitude(longint'(dx));
        ay = magnitude(longint'(dy));
        m = ax > ay ? ax : ay;
        ux = 0;
        uy = 0;
        if (m != 0) begin
            while (m < (64'd1 << UB)) begin
                m = m << 1;
                ax = ax << 1;
                ay = ay << 1;
            end
            mag = int_sqrt(ax * ax + ay * ay);
            ux = (ax << UB) / mag;
            uy = (ay << UB) / mag;
            if (dx < 0) ux = -ux;
            if (dy < 0) uy = -uy;
        end
        fx = longint'(px) - longint'(sx);
        fy = longint'(py) - longint'(sy);
        t = floor_div_unit(ux * fx + uy * fy);
        if (t >= longint'(len)) tc = longint'(len);
        else if (t <= 0) tc = 0;
        else tc = t;
        ex = rounded_residual(fx * UNIT_ONE - ux * tc);
        ey = rounded_residual(fy * UNIT_ONE - uy * tc);
        if (ex > 64'hFFFF_FFFF || ey > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
        sqx = ex * ex;
        sqy = ey * ey;
        sum = sqx + sqy;
        if (sum < sqx) return 32'hFFFF_FFFF;
        return 32'(int_sqrt(sum));
    endfunction

    assign pending = distance_q.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fail_count <= 0;
        end else begin
            if (start && !busy)
                distance_q.push_back(seg_distance(i_point_x, i_point_y, i_seg_start_x,
                    i_seg_start_y, i_dir_x, i_dir_y, i_seg_length));
            if (o_strobe) begin
                if (distance_q.size() == 0) begin
                    $display("%0t: unexpected distance word %h", $time, o_distance);
                    fail_count <= fail_count + 1;
                end else if (distance_q[0] !== o_distance) begin
                    $display("%0t: distance expected %h actual %h", $time, distance_q[0],
                        o_distance);
                    fail_count <= fail_count + 1;
                    void'(distance_q.pop_front());
                end else begin
                    void'(distance_q.pop_front());
                end
            end
        end
    end
endmodule

@@ tb/sv/point_to_segment_distance_test.sv @@
// Top of the point-to-segment distance testbench: stimulus, watchdog and verdict.
module point_to_segment_distance_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_point_x = '0, i_point_y = '0, i_seg_start_x = '0, i_seg_start_y = '0;
    logic [31:0] i_dir_x = '0, i_dir_y = '0, i_seg_length = '0;
    logic        o_strobe;
    logic [31:0] o_distance;
    int          fail_count;
    int          pending;
    int          idle_cycles;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    point_to_segment_distance u_top (.*);

    point_to_segment_distance_checker u_checker (.*);

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("point_to_segment_distance_test: FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            3: begin
                case ($urandom_range(0, 5))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0;
                    3: return 32'hFFFF_FFFF;
                    4: return 32'h1;
                    default: return 32'h0001_0000;
                endcase
            end
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic send_word(logic [31:0] px, logic [31:0] py, logic [31:0] sx,
            logic [31:0] sy, logic [31:0] dx, logic [31:0] dy, logic [31:0] len);
        i_point_x     <= px;
        i_point_y     <= py;
        i_seg_start_x <= sx;
        i_seg_start_y <= sy;
        i_dir_x       <= dx;
        i_dir_y       <= dy;
        i_seg_length  <= len;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_gap(bit steady);
        int gap;
        gap = 0;
        if (!steady) begin
            gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
            if ($urandom_range(0, 40) == 0) gap = $urandom_range(10, 60);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;

    initial begin
        int mode;
        bit steady;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: zero direction, clamps, negative length, extremes, overflow
        send_word(3 * ONE, 4 * ONE, 0, 0, 0, 0, 10 * ONE);
        send_word(5 * ONE, 2 * ONE, 0, 0, ONE, 0, 10 * ONE);
        send_word(-5 * ONE, 2 * ONE, 0, 0, ONE, 0, 10 * ONE);
        send_word(20 * ONE, 2 * ONE, 0, 0, 7, 0, 10 * ONE);
        send_word(5 * ONE, 5 * ONE, 0, 0, 3 * ONE, 3 * ONE, -4 * ONE);
        send_word(-5 * ONE, -5 * ONE, 0, 0, ONE, ONE, -4 * ONE);
        send_word(ONE, ONE, ONE, ONE, -ONE, ONE, 0);
        send_word(MAXV, MAXV, MINV, MINV, 0, 0, 0);
        send_word(MINV, MAXV, MAXV, MINV, 0, 0, MAXV);
        send_word(MAXV, MINV, MINV, MAXV, MINV, MINV, MINV);
        send_word(MAXV, MAXV, MINV, MINV, MAXV, MAXV, MAXV);
        send_word(MINV, MINV, MAXV, MAXV, MINV, 0, MAXV);
        send_word(0, 0, 0, 0, MAXV, 1, MAXV);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1, 32'hFFFF_FFFF, 1);
        send_word(0, 0, MINV, MINV, 0, MINV, MINV);
        send_word(ONE, 0, 0, 0, 0, 1, MAXV);
        steady = 0;
        for (int n = 0; n < 1950; n++) begin
            if (n % 200 == 0) steady = $urandom_range(0, 2) == 0;
            mode = $urandom_range(0, 4);
            send_word(pick_value(mode), pick_value(mode), pick_value(mode), pick_value(mode),
                pick_value($urandom_range(0, 4)), pick_value($urandom_range(0, 4)),
                pick_value($urandom_range(0, 4)));
            idle_gap(steady);
        end
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("point_to_segment_distance_test: PASS");
        else
            $display("point_to_segment_distance_test: FAIL");
        $finish;
    end
endmodule
